@@ src/grb_pkg.sv @@
package grb_pkg;

  // grid geometry and count width
  localparam int GRID_ROWS  = 64;
  localparam int GRID_COLS  = 64;
  localparam int COUNT_BITS = 16;

  localparam int ROW_BITS  = $clog2(GRID_ROWS);
  localparam int COL_BITS  = $clog2(GRID_COLS);
  localparam int ADDR_W    = ROW_BITS + COL_BITS;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  // fixed field widths
  localparam int IDX_W  = 6;
  localparam int VAL_W  = 16;
  localparam int LVL_W  = 5;
  localparam int SIZE_W = 16;

  // datapath widths
  localparam int LINE_BITS = (ROW_BITS > COL_BITS) ? ROW_BITS : COL_BITS;
  localparam int LINE_W    = COUNT_BITS + LINE_BITS;
  localparam int SUM_W     = COUNT_BITS + ADDR_W;
  localparam int DIST_W    = SUM_W + 2;
  localparam int HD_W      = SUM_W + 1;
  localparam int SPAN_W    = IDX_W + 1;
  localparam int SIDE_W    = SPAN_W + SIZE_W;

  localparam int MIN_POINTS = 4;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_LEVEL,
    REG_CELL_WIDTH,
    REG_CELL_HEIGHT
  } reg_idx_t;

  typedef enum logic {
    CMD_WRITE,
    CMD_SPLIT
  } cmd_t;

  typedef enum logic [2:0] {
    OUT_SPLIT,
    OUT_LEVEL,
    OUT_FEW,
    OUT_NARROW,
    OUT_LEADING
  } outcome_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_CHECK,
    S_READ,
    S_EVAL,
    S_DECIDE
  } scan_state_t;

  typedef struct packed {
    logic [LVL_W-1:0]  max_level;
    logic [SIZE_W-1:0] cell_width;
    logic [SIZE_W-1:0] cell_height;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] first_row;
    logic [IDX_W-1:0] last_row;
    logic [IDX_W-1:0] first_col;
    logic [IDX_W-1:0] last_col;
    logic [VAL_W-1:0] node_points;
    logic [LVL_W-1:0] node_level;
  } req_t;

  typedef struct packed {
    logic             valid;
    outcome_t         outcome;
    logic             axis;
    logic [IDX_W-1:0] at;
    logic [VAL_W-1:0] first_count;
    logic [VAL_W-1:0] second_count;
  } result_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
    logic [31:0] rr;
    logic [31:0] cc;
    rr = 32'(r);
    cc = 32'(c);
    return {rr[ROW_BITS-1:0], cc[COL_BITS-1:0]};
  endfunction

  function automatic logic in_grid(input logic [IDX_W-1:0] r,
                                   input logic [IDX_W-1:0] c);
    return (32'(r) < 32'(GRID_ROWS)) && (32'(c) < 32'(GRID_COLS));
  endfunction

  // |total - 2 * part|
  function automatic logic [HD_W-1:0] half_dist(input logic [VAL_W-1:0] total,
                                                input logic [SUM_W-1:0] part);
    logic signed [DIST_W-1:0] d;
    d = $signed(DIST_W'(total)) - $signed({1'b0, part, 1'b0});
    return (d < 0) ? HD_W'(-d) : HD_W'(d);
  endfunction

endpackage

@@ src/grb_ram.sv @@
module grb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/grb_scan.sv @@
module grb_scan import grb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  req_t                  req,
  input  cfg_t                  cfg,
  output logic                  rd_en,
  output logic [ADDR_W-1:0]     rd_addr,
  input  logic [COUNT_BITS-1:0] rd_data,
  output logic                  busy,
  output result_t               res
);

  scan_state_t st_r, st_nxt;
  result_t     res_r, res_nxt;
  logic        rv_r, rv_nxt;
  logic        rlast_r, rlast_nxt;
  logic        rin_r, rin_nxt;

  req_t              req_r, req_nxt;
  logic [SIDE_W-1:0] xd_r, xd_nxt;
  logic [SIDE_W-1:0] yd_r, yd_nxt;
  logic              cols_r, cols_nxt;
  logic [IDX_W-1:0]  last_r, last_nxt;
  logic [IDX_W-1:0]  lo_r, lo_nxt;
  logic [IDX_W-1:0]  hi_r, hi_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic              issued_r, issued_nxt;
  logic              first_r, first_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [SUM_W-1:0]  cur_r, cur_nxt;
  logic [SUM_W-1:0]  nsum_r, nsum_nxt;
  logic [HD_W-1:0]   d1_r, d1_nxt;

  logic [SPAN_W-1:0] xspan;
  logic [SPAN_W-1:0] yspan;
  logic              cols_c;
  logic [IDX_W-1:0]  rd_row;
  logic [IDX_W-1:0]  rd_col;
  logic [HD_W-1:0]   d2;
  logic [SUM_W-1:0]  total_w;

  assign xspan   = {1'b0, req_r.last_col} - {1'b0, req_r.first_col} + SPAN_W'(1);
  assign yspan   = {1'b0, req_r.last_row} - {1'b0, req_r.first_row} + SPAN_W'(1);
  assign cols_c  = xd_r > yd_r;
  assign rd_row  = cols_r ? k_r : idx_r;
  assign rd_col  = cols_r ? idx_r : k_r;
  assign rd_addr = cell_addr(rd_row, rd_col);
  assign d2      = half_dist(req_r.node_points, nsum_r);
  assign total_w = SUM_W'(req_r.node_points);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      res_r   <= '0;
      rv_r    <= 1'b0;
      rlast_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      res_r   <= res_nxt;
      rv_r    <= rv_nxt;
      rlast_r <= rlast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    xd_r     <= xd_nxt;
    yd_r     <= yd_nxt;
    cols_r   <= cols_nxt;
    last_r   <= last_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    idx_r    <= idx_nxt;
    k_r      <= k_nxt;
    issued_r <= issued_nxt;
    first_r  <= first_nxt;
    line_r   <= line_nxt;
    cur_r    <= cur_nxt;
    nsum_r   <= nsum_nxt;
    d1_r     <= d1_nxt;
    rin_r    <= rin_nxt;
  end

  always_comb begin
    st_nxt     = st_r;
    res_nxt    = res_r;
    res_nxt.valid = 1'b0;
    req_nxt    = req_r;
    xd_nxt     = xd_r;
    yd_nxt     = yd_r;
    cols_nxt   = cols_r;
    last_nxt   = last_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    idx_nxt    = idx_r;
    k_nxt      = k_r;
    issued_nxt = issued_r;
    first_nxt  = first_r;
    line_nxt   = line_r;
    cur_nxt    = cur_r;
    nsum_nxt   = nsum_r;
    d1_nxt     = d1_r;
    rd_en      = 1'b0;
    rlast_nxt  = 1'b0;
    rin_nxt    = in_grid(rd_row, rd_col);

    unique case (st_r)
      S_IDLE: begin
        if (go) begin
          req_nxt = req;
          if (req.node_level == cfg.max_level) begin
            res_nxt = '0;
            res_nxt.valid = 1'b1;
            res_nxt.outcome = OUT_LEVEL;
          end else if (req.node_points < VAL_W'(MIN_POINTS)) begin
            res_nxt = '0;
            res_nxt.valid = 1'b1;
            res_nxt.outcome = OUT_FEW;
          end else if (req.last_row < req.first_row || req.last_col < req.first_col) begin
            res_nxt = '0;
            res_nxt.valid = 1'b1;
            res_nxt.outcome = OUT_NARROW;
          end else begin
            st_nxt = S_PREP;
          end
        end
      end
      S_PREP: begin
        // physical side lengths
        xd_nxt = SIDE_W'(xspan) * SIDE_W'(cfg.cell_width);
        yd_nxt = SIDE_W'(yspan) * SIDE_W'(cfg.cell_height);
        st_nxt = S_CHECK;
      end
      S_CHECK: begin
        cols_nxt = cols_c;
        last_nxt = cols_c ? req_r.last_col : req_r.last_row;
        lo_nxt   = cols_c ? req_r.first_row : req_r.first_col;
        hi_nxt   = cols_c ? req_r.last_row : req_r.last_col;
        idx_nxt  = cols_c ? req_r.first_col : req_r.first_row;
        if (idx_nxt == last_nxt) begin
          res_nxt = '0;
          res_nxt.valid = 1'b1;
          res_nxt.outcome = OUT_NARROW;
          st_nxt = S_IDLE;
        end else begin
          k_nxt      = lo_nxt;
          issued_nxt = 1'b0;
          line_nxt   = '0;
          first_nxt  = 1'b1;
          st_nxt     = S_READ;
        end
      end
      S_READ: begin
        if (!issued_r) begin
          rd_en     = 1'b1;
          rlast_nxt = (k_r == hi_r);
          if (k_r == hi_r) begin
            issued_nxt = 1'b1;
          end else begin
            k_nxt = k_r + IDX_W'(1);
          end
        end
        if (rv_r) begin
          line_nxt = line_r + (rin_r ? LINE_W'(rd_data) : LINE_W'(0));
          if (rlast_r) begin
            st_nxt = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (first_r) begin
          cur_nxt = SUM_W'(line_r);
          if (SUM_W'(line_r) == total_w) begin
            res_nxt = '0;
            res_nxt.valid = 1'b1;
            res_nxt.outcome = OUT_LEADING;
            st_nxt = S_IDLE;
          end else begin
            first_nxt  = 1'b0;
            idx_nxt    = idx_r + IDX_W'(1);
            k_nxt      = lo_r;
            issued_nxt = 1'b0;
            line_nxt   = '0;
            st_nxt     = S_READ;
          end
        end else begin
          nsum_nxt = cur_r + SUM_W'(line_r);
          d1_nxt   = half_dist(req_r.node_points, cur_r);
          st_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (idx_r == last_r || d1_r < d2) begin
          res_nxt = '0;
          res_nxt.valid = 1'b1;
          res_nxt.outcome = OUT_SPLIT;
          res_nxt.axis = !cols_r;
          res_nxt.at = idx_r;
          res_nxt.first_count = (cur_r > SUM_W'(16'hFFFF)) ? 16'hFFFF : cur_r[VAL_W-1:0];
          res_nxt.second_count = (cur_r > total_w) ? '0 :
                                 req_r.node_points - cur_r[VAL_W-1:0];
          st_nxt = S_IDLE;
        end else begin
          cur_nxt = nsum_r;
          if (nsum_r == total_w) begin
            res_nxt = '0;
            res_nxt.valid = 1'b1;
            res_nxt.outcome = OUT_LEADING;
            st_nxt = S_IDLE;
          end else begin
            idx_nxt    = idx_r + IDX_W'(1);
            k_nxt      = lo_r;
            issued_nxt = 1'b0;
            line_nxt   = '0;
            st_nxt     = S_READ;
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
    rv_nxt = rd_en;
  end

  assign busy = (st_r != S_IDLE);
  assign res  = res_r;

endmodule

@@ src/grid_region_balanced_split_top.sv @@
// grid region balanced split
// holds a 64 by 64 grid of per-cell point counts and splits a rectangle of
// cells into two parts of near equal count, across its longer physical side
//
// input channel: an item is taken at a rising edge with start high and busy
// low. a write item (in_command = 0) stores one cell count in that cycle and
// gives no result; a split item (in_command = 1) gives exactly one result
// result channel: out_valid marks each result for one cycle; the receiver
// cannot stall, so results are never held back or repeated
// config channel: cfg_valid/cfg_ready write max_level, cell_width and
// cell_height by cfg_index; cfg_ready is always high, write only when idle
//
// result timing: a split rejected on level, point total or reversed bounds
// shows its result in the cycle after accept. a scanned split's result is
// paced by the one count memory read port (one cell a cycle within a line)
// and the shared line adder
// reset: the count memory is swept to zero, one cell a cycle, with busy high;
// config writes are still taken during the sweep
module grid_region_balanced_split_top import grb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_command,
  input  logic [IDX_W-1:0]      in_cell_row,
  input  logic [IDX_W-1:0]      in_cell_col,
  input  logic [VAL_W-1:0]      in_cell_value,
  input  logic [IDX_W-1:0]      in_first_row,
  input  logic [IDX_W-1:0]      in_last_row,
  input  logic [IDX_W-1:0]      in_first_col,
  input  logic [IDX_W-1:0]      in_last_col,
  input  logic [VAL_W-1:0]      in_node_points,
  input  logic [LVL_W-1:0]      in_node_level,
  // result channel
  output logic                  out_valid,
  output logic [2:0]            out_outcome,
  output logic                  out_split_axis,
  output logic [IDX_W-1:0]      out_split_at,
  output logic [VAL_W-1:0]      out_first_count,
  output logic [VAL_W-1:0]      out_second_count,
  // config channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  cfg_t cfg_r, cfg_nxt;

  // reset clearing sweep of the count memory
  logic              clr_active_r, clr_active_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  logic                  accept;
  logic                  wr_item;
  logic                  split_go;
  logic                  scan_busy;
  req_t                  req;
  result_t               res;

  // count memory ports
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic                  mem_re;
  logic [ADDR_W-1:0]     mem_raddr;
  logic [COUNT_BITS-1:0] mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_level   <= LVL_W'(31);
      cfg_r.cell_width  <= SIZE_W'(1);
      cfg_r.cell_height <= SIZE_W'(1);
      clr_active_r      <= 1'b1;
      clr_addr_r        <= '0;
    end else begin
      cfg_r        <= cfg_nxt;
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
    end
  end

  // register decode; an index past the list is dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_LEVEL:   cfg_nxt.max_level   = cfg_data[LVL_W-1:0];
        REG_CELL_WIDTH:  cfg_nxt.cell_width  = cfg_data[SIZE_W-1:0];
        REG_CELL_HEIGHT: cfg_nxt.cell_height = cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sweep walks every cell once after reset
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(MEM_DEPTH - 1)) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  assign busy     = clr_active_r | scan_busy;
  assign accept   = start && !busy;
  assign split_go = accept && (in_command == CMD_SPLIT);
  // writes outside the grid are dropped
  assign wr_item  = accept && (in_command == CMD_WRITE) && in_grid(in_cell_row, in_cell_col);

  assign mem_we    = clr_active_r | wr_item;
  assign mem_waddr = clr_active_r ? clr_addr_r : cell_addr(in_cell_row, in_cell_col);
  assign mem_wdata = clr_active_r ? '0 : COUNT_BITS'(in_cell_value);

  assign req.first_row   = in_first_row;
  assign req.last_row    = in_last_row;
  assign req.first_col   = in_first_col;
  assign req.last_col    = in_last_col;
  assign req.node_points = in_node_points;
  assign req.node_level  = in_node_level;

  grb_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_counts (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer with the shared line adder and the half-distance compare
  grb_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (split_go),
    .req     (req),
    .cfg     (cfg_r),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata),
    .busy    (scan_busy),
    .res     (res)
  );

  // result straight from the sequencer's output register
  assign out_valid        = res.valid;
  assign out_outcome      = res.outcome;
  assign out_split_axis   = res.axis;
  assign out_split_at     = res.at;
  assign out_first_count  = res.first_count;
  assign out_second_count = res.second_count;

endmodule

@@ src/grb_checker.sv @@
module grb_checker import grb_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             busy,
  input logic             out_valid,
  input logic [2:0]       out_outcome,
  input logic             out_split_axis,
  input logic [IDX_W-1:0] out_split_at,
  input logic [VAL_W-1:0] out_first_count,
  input logic [VAL_W-1:0] out_second_count
);

  // reset starts the clearing sweep and drops any result
  a_reset_sweep: assert property (@(posedge clk)
    !rst_n |=> busy && !out_valid)
    else $error("no sweep or stray result after reset");

  // a result only leaves when the sequencer is back to idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  // no split: the split fields stay zero
  a_nosplit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome != OUT_SPLIT |->
      !out_split_axis && out_split_at == '0 && out_first_count == '0 &&
      out_second_count == '0)
    else $error("split fields set without a split");

  // a split always lies past at least one leading line
  a_split_past_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome == OUT_SPLIT |-> out_split_at != '0)
    else $error("split at index zero");

endmodule

bind grid_region_balanced_split_top grb_checker u_grb_checker (.*);
